@@ design/tq_pkg.sv @@
// tq_pkg: shared types and codes for the sorted timer queue.
// Holds operation, status and sequencer state codes and the compare flag struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tq_pkg;

    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    // operation codes of an input transaction
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_ADJUST = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    // status codes of a result transaction
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FD_RD,
        S_FD_CMP,
        S_RM_RD,
        S_RM_WR,
        S_IN_RD,
        S_IN_CMP,
        S_SH_RD,
        S_SH_WR,
        S_TK_RD,
        S_TK_CMP
    } t_state;

    // flags from the shared compare unit
    typedef struct packed {
        logic le;     // stored expiry at or before the key time
        logic id_eq;  // stored id equals the key id
    } t_cmp_flags;

endpackage

`default_nettype wire

@@ design/tq_store.sv @@
// tq_store: entry memory of the timer queue, ids and expiry times in list order.
// One write port, one read port with registered read data. Uses tq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tq_store
    import tq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IW       = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [IW-1:0]     i_wr_addr,
    input  wire logic [ID_W-1:0]   i_wr_id,
    input  wire logic [TIME_W-1:0] i_wr_exp,
    input  wire logic [IW-1:0]     i_rd_addr,
    output logic      [ID_W-1:0]   o_rd_id,
    output logic      [TIME_W-1:0] o_rd_exp
);

    logic [ID_W-1:0]   r_id_mem  [CAPACITY];
    logic [TIME_W-1:0] r_exp_mem [CAPACITY];

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_id_mem[i_wr_addr]  <= i_wr_id;
            r_exp_mem[i_wr_addr] <= i_wr_exp;
        end
    end

    // read one entry every cycle
    always_ff @(posedge i_clk) begin
        o_rd_id  <= r_id_mem[i_rd_addr];
        o_rd_exp <= r_exp_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ design/tq_cmp.sv @@
// tq_cmp: shared compare unit, checks the entry just read against the key.
// Purely combinational. Uses tq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tq_cmp
    import tq_pkg::*;
(
    input  wire logic [ID_W-1:0]   i_rd_id,
    input  wire logic [TIME_W-1:0] i_rd_exp,
    input  wire logic [ID_W-1:0]   i_key_id,
    input  wire logic [TIME_W-1:0] i_key_time,
    output t_cmp_flags             o_flags
);

    // compare id and expiry of one entry
    assign o_flags.le    = (i_rd_exp <= i_key_time);
    assign o_flags.id_eq = (i_rd_id == i_key_id);

endmodule

`default_nettype wire

@@ design/tq_seq.sv @@
// tq_seq: sequencer of the timer queue; walks the entry memory one entry per step,
// drives the shared compare unit and holds the result register. Uses tq_pkg, tq_cmp.
`timescale 1ns / 1ps
`default_nettype none

module tq_seq
    import tq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IW       = 4,
    parameter int CW       = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [ID_W-1:0]     i_timer_id,
    input  wire logic [TIME_W-1:0]   i_expire_time,
    input  wire logic [TIME_W-1:0]   i_now_time,
    // result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [ID_W-1:0]     o_expired_id,
    output logic      [TIME_W-1:0]   o_expired_at,
    output logic                     o_last,
    // entry memory
    output logic                     o_wr_en,
    output logic      [IW-1:0]       o_wr_addr,
    output logic      [ID_W-1:0]     o_wr_id,
    output logic      [TIME_W-1:0]   o_wr_exp,
    output logic      [IW-1:0]       o_rd_addr,
    input  wire logic [ID_W-1:0]     i_rd_id,
    input  wire logic [TIME_W-1:0]   i_rd_exp
);

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [TIME_W-1:0] r_exp, n_exp;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_old, n_old;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_count, n_count;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [TIME_W-1:0]   r_out_at, n_out_at;
    logic                r_out_last, n_out_last;
    logic                w_load;

    logic              w_can_load;
    logic              w_full;
    logic [CW-1:0]     w_idx_inc;
    logic [CW-1:0]     w_idx_dec;
    logic [TIME_W-1:0] w_key_time;
    t_cmp_flags        w_flags;

    assign w_can_load = !r_out_valid || !i_stall;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_idx_inc  = r_idx + 1'b1;
    assign w_idx_dec  = r_idx - 1'b1;
    assign w_key_time = (r_op == OP_TICK) ? r_now : r_exp;

    // shared compare of the entry just read
    tq_cmp u_cmp (
        .i_rd_id    (i_rd_id),
        .i_rd_exp   (i_rd_exp),
        .i_key_id   (r_id),
        .i_key_time (w_key_time),
        .o_flags    (w_flags)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (t_op'(i_op) == OP_TICK) ? S_TK_RD : S_FD_RD;
                end
            end
            S_FD_RD: begin
                if (r_idx < r_count) begin
                    n_state = S_FD_CMP;
                end else if (r_op == OP_INSERT && !w_full) begin
                    n_state = S_IN_RD;
                end else if (w_can_load) begin
                    n_state = S_IDLE;
                end
            end
            S_FD_CMP: begin
                if (!w_flags.id_eq) begin
                    n_state = S_FD_RD;
                end else if (r_op == OP_INSERT) begin
                    if (w_can_load) n_state = S_IDLE;
                end else begin
                    n_state = S_RM_RD;
                end
            end
            S_RM_RD: begin
                if (w_idx_inc < r_count) begin
                    n_state = S_RM_WR;
                end else begin
                    unique case (r_op)
                        OP_DELETE: if (w_can_load) n_state = S_IDLE;
                        OP_ADJUST: n_state = S_IN_RD;
                        OP_TICK:   n_state = S_TK_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RM_WR: n_state = S_RM_RD;
            S_IN_RD: n_state = (r_idx < r_count) ? S_IN_CMP : S_SH_RD;
            S_IN_CMP: n_state = w_flags.le ? S_IN_RD : S_SH_RD;
            S_SH_RD: begin
                if (r_idx > r_pos) begin
                    n_state = S_SH_WR;
                end else if (w_can_load) begin
                    n_state = S_IDLE;
                end
            end
            S_SH_WR: n_state = S_SH_RD;
            S_TK_RD: begin
                if (r_count != '0) begin
                    n_state = S_TK_CMP;
                end else if (w_can_load) begin
                    n_state = S_IDLE;
                end
            end
            S_TK_CMP: begin
                if (w_can_load) n_state = w_flags.le ? S_RM_RD : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory controls and result load
    always_comb begin
        n_op         = r_op;
        n_id         = r_id;
        n_exp        = r_exp;
        n_now        = r_now;
        n_old        = r_old;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_count      = r_count;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_at     = r_out_at;
        n_out_last   = r_out_last;
        w_load       = 1'b0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx[IW-1:0];
        o_wr_id      = i_rd_id;
        o_wr_exp     = i_rd_exp;
        o_rd_addr    = r_idx[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op  = t_op'(i_op);
                    n_id  = i_timer_id;
                    n_exp = i_expire_time;
                    n_now = i_now_time;
                    n_idx = '0;
                end
            end
            S_FD_RD: begin
                if (r_idx < r_count) begin
                    // read issued at r_idx
                end else if (r_op == OP_INSERT && !w_full) begin
                    n_idx = '0;
                end else if (w_can_load) begin
                    w_load       = 1'b1;
                    n_out_status = (r_op == OP_INSERT) ? ST_FULL : ST_NOTFOUND;
                    n_out_id     = r_id;
                    n_out_at     = (r_op == OP_INSERT) ? r_exp : '0;
                    n_out_last   = 1'b1;
                end
            end
            S_FD_CMP: begin
                if (!w_flags.id_eq) begin
                    n_idx = w_idx_inc;
                end else if (r_op == OP_INSERT) begin
                    if (w_can_load) begin
                        w_load       = 1'b1;
                        n_out_status = ST_DUP;
                        n_out_id     = r_id;
                        n_out_at     = i_rd_exp;
                        n_out_last   = 1'b1;
                    end
                end else begin
                    n_old = i_rd_exp;
                end
            end
            S_RM_RD: begin
                // fetch the successor, or close the gap
                o_rd_addr = w_idx_inc[IW-1:0];
                if (w_idx_inc >= r_count) begin
                    if (r_op == OP_DELETE) begin
                        if (w_can_load) begin
                            n_count      = r_count - 1'b1;
                            w_load       = 1'b1;
                            n_out_status = ST_DONE;
                            n_out_id     = r_id;
                            n_out_at     = r_old;
                            n_out_last   = 1'b1;
                        end
                    end else begin
                        n_count = r_count - 1'b1;
                        n_idx   = '0;
                    end
                end
            end
            S_RM_WR: begin
                o_wr_en = 1'b1;
                n_idx   = w_idx_inc;
            end
            S_IN_RD: begin
                if (r_idx >= r_count) n_pos = r_idx;
            end
            S_IN_CMP: begin
                if (w_flags.le) begin
                    n_idx = w_idx_inc;
                end else begin
                    n_pos = r_idx;
                    n_idx = r_count;
                end
            end
            S_SH_RD: begin
                // move entries up one place, then drop the new one in
                o_rd_addr = w_idx_dec[IW-1:0];
                if (r_idx <= r_pos && w_can_load) begin
                    o_wr_en      = 1'b1;
                    o_wr_addr    = r_pos[IW-1:0];
                    o_wr_id      = r_id;
                    o_wr_exp     = r_exp;
                    n_count      = r_count + 1'b1;
                    w_load       = 1'b1;
                    n_out_status = ST_DONE;
                    n_out_id     = r_id;
                    n_out_at     = r_exp;
                    n_out_last   = 1'b1;
                end
            end
            S_SH_WR: begin
                o_wr_en = 1'b1;
                n_idx   = w_idx_dec;
            end
            S_TK_RD: begin
                if (r_count == '0 && w_can_load) begin
                    w_load       = 1'b1;
                    n_out_status = ST_DONE;
                    n_out_id     = '0;
                    n_out_at     = r_now;
                    n_out_last   = 1'b1;
                end
            end
            S_TK_CMP: begin
                if (w_can_load) begin
                    w_load = 1'b1;
                    if (w_flags.le) begin
                        n_out_status = ST_EXPIRED;
                        n_out_id     = i_rd_id;
                        n_out_at     = i_rd_exp;
                        n_out_last   = 1'b0;
                        n_idx        = '0;
                    end else begin
                        n_out_status = ST_DONE;
                        n_out_id     = '0;
                        n_out_at     = r_now;
                        n_out_last   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= w_load ? 1'b1 : (r_out_valid && i_stall);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_exp        <= n_exp;
        r_now        <= n_now;
        r_old        <= n_old;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_at     <= n_out_at;
        r_out_last   <= n_out_last;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_expired_id = r_out_id;
    assign o_expired_at = r_out_at;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

@@ design/sorted_timer_queue.sv @@
// sorted_timer_queue: top level of the sorted timer list.
// Instantiates tq_store (entry memory) and tq_seq (sequencer with compare unit).
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_op, i_timer_id, i_expire_time, i_now_time
//   result    out        o_valid / i_stall   o_status, o_expired_id, o_expired_at, o_last
//
// Steps: every memory step reads through the single registered read port, then
// compares or writes. Insert, delete and adjust scan the entries and then move entries;
// a tick removes each expired entry from the head and ends with a final compare (none on
// an empty list).
// Reset: synchronous, active low; clears the state, the entry count and the result valid, no clearing pass.
// Stalls: o_stall stays high until the final result of a transaction is loaded; a
// result waits in the output register and the sequencer holds while it is stalled.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_timer_id,
    input  wire logic [31:0] i_expire_time,
    input  wire logic [31:0] i_now_time,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [2:0]  o_status,
    output logic      [7:0]  o_expired_id,
    output logic      [31:0] o_expired_at,
    output logic             o_last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    logic [7:0]    w_wr_id;
    logic [31:0]   w_wr_exp;
    logic [IW-1:0] w_rd_addr;
    logic [7:0]    w_rd_id;
    logic [31:0]   w_rd_exp;

    // entry memory
    tq_store #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_id   (w_wr_id),
        .i_wr_exp  (w_wr_exp),
        .i_rd_addr (w_rd_addr),
        .o_rd_id   (w_rd_id),
        .o_rd_exp  (w_rd_exp)
    );

    // sequencer
    tq_seq #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_timer_id    (i_timer_id),
        .i_expire_time (i_expire_time),
        .i_now_time    (i_now_time),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_expired_id  (o_expired_id),
        .o_expired_at  (o_expired_at),
        .o_last        (o_last),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_id       (w_wr_id),
        .o_wr_exp      (w_wr_exp),
        .o_rd_addr     (w_rd_addr),
        .i_rd_id       (w_rd_id),
        .i_rd_exp      (w_rd_exp)
    );

endmodule

`default_nettype wire

@@ design/tq_checker.sv @@
// tq_checker: port-level assertions for sorted_timer_queue, bound to the top level.
// Uses tq_pkg status codes.
`timescale 1ns / 1ps
`default_nettype none

module tq_checker
    import tq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_expired_id,
    input wire logic [31:0] o_expired_at,
    input wire logic        o_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_expired_id)
            && $stable(o_expired_at) && $stable(o_last))
        else $error("stalled result changed");

    // only expirations come before the final result of a transaction
    a_mid_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_status == ST_EXPIRED)
        else $error("non-final result is not an expiration");

    // an expiration is never the final result
    a_expired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EXPIRED |-> !o_last)
        else $error("expiration flagged as final result");

    // an accepted transaction keeps the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted without going busy");

endmodule

bind sorted_timer_queue tq_checker u_tq_checker (.*);

`default_nettype wire

@@ tb/sv/tb_sorted_timer_queue.sv @@
// tb_sorted_timer_queue: self-checking bench for the sorted timer list.
// Holds its own copy of the list, the expected status queue and random stimulus.
// Depends on tq_pkg and sorted_timer_queue.
`timescale 1ns / 1ps

module tb_sorted_timer_queue
    import tq_pkg::*;
();

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_OPS  = 140;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   at;
        logic                last;
    } t_timer_result;

    // Timer list copy plus the statuses it still owes
    class timer_list_scoreboard;
        bit [TIME_W-1:0] expiry_list [QUEUE_DEPTH];
        bit [ID_W-1:0]   id_list [QUEUE_DEPTH];
        int              used;
        t_timer_result   owed_results [$];
        int              errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        function int find_id(logic [ID_W-1:0] id);
            for (int i = 0; i < used; i++) begin
                if (id_list[i] == id)
                    return i;
            end
            return used;
        endfunction

        // close the gap left by the removed entry
        function void remove_entry(int pos);
            for (int i = pos; i + 1 < used; i++) begin
                expiry_list[i] = expiry_list[i+1];
                id_list[i]     = id_list[i+1];
            end
            used--;
        endfunction

        // place after every entry with an equal or earlier expiry
        function void insert_sorted(logic [ID_W-1:0] id, logic [TIME_W-1:0] exp);
            int pos;
            pos = 0;
            while (pos < used && expiry_list[pos] <= exp)
                pos++;
            for (int i = used; i > pos; i--) begin
                expiry_list[i] = expiry_list[i-1];
                id_list[i]     = id_list[i-1];
            end
            expiry_list[pos] = exp;
            id_list[pos]     = id;
            used++;
        endfunction

        function void owe(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
                          logic [TIME_W-1:0] at, logic fin);
            t_timer_result res;
            res.status = st;
            res.id     = id;
            res.at     = at;
            res.last   = fin;
            owed_results.push_back(res);
        endfunction

        // Update the list for one accepted transaction and note its statuses
        function void apply_timer_op(t_op op, logic [ID_W-1:0] id,
                                     logic [TIME_W-1:0] exp, logic [TIME_W-1:0] now);
            int              pos;
            logic [TIME_W-1:0] old_exp;
            pos = find_id(id);
            case (op)
                OP_INSERT: begin
                    if (pos < used)
                        owe(ST_DUP, id, expiry_list[pos], 1'b1);
                    else if (used >= QUEUE_DEPTH)
                        owe(ST_FULL, id, exp, 1'b1);
                    else begin
                        insert_sorted(id, exp);
                        owe(ST_DONE, id, exp, 1'b1);
                    end
                end
                OP_DELETE: begin
                    if (pos >= used)
                        owe(ST_NOTFOUND, id, '0, 1'b1);
                    else begin
                        old_exp = expiry_list[pos];
                        remove_entry(pos);
                        owe(ST_DONE, id, old_exp, 1'b1);
                    end
                end
                OP_ADJUST: begin
                    if (pos >= used)
                        owe(ST_NOTFOUND, id, '0, 1'b1);
                    else begin
                        remove_entry(pos);
                        insert_sorted(id, exp);
                        owe(ST_DONE, id, exp, 1'b1);
                    end
                end
                default: begin
                    // drain every entry due at or before now, head first
                    while (used > 0 && expiry_list[0] <= now) begin
                        owe(ST_EXPIRED, id_list[0], expiry_list[0], 1'b0);
                        remove_entry(0);
                    end
                    owe(ST_DONE, '0, now, 1'b1);
                end
            endcase
        endfunction

        function void report(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        // Compare one accepted status transaction with the oldest owed one
        function void check_timer_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
                                         logic [TIME_W-1:0] at, logic fin);
            t_timer_result want;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0h id %0h at %0h last %0h",
                         $time, st, id, at, fin);
                return;
            end
            want = owed_results.pop_front();
            if (st !== want.status)
                report("status", want.status, st);
            if (id !== want.id)
                report("expired_id", want.id, id);
            if (at !== want.at)
                report("expired_at", want.at, at);
            if (fin !== want.last)
                report("last", want.last, fin);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [OP_W-1:0]   i_op;
    logic [ID_W-1:0]   i_timer_id;
    logic [TIME_W-1:0] i_expire_time;
    logic [TIME_W-1:0] i_now_time;
    logic              o_valid;
    logic              i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]   o_expired_id;
    logic [TIME_W-1:0] o_expired_at;
    logic              o_last;

    timer_list_scoreboard board;
    bit                calm_tx;
    int                calm_tx_left;
    int                results_seen;

    sorted_timer_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_timer_id    (i_timer_id),
        .i_expire_time (i_expire_time),
        .i_now_time    (i_now_time),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_expired_id  (o_expired_id),
        .o_expired_at  (o_expired_at),
        .o_last        (o_last)
    );

    always #2 i_clk = ~i_clk;

    // Sender gap: mostly short, a few long, with stretches of back-to-back traffic
    function automatic int next_gap();
        int r;
        if (calm_tx_left == 0) begin
            calm_tx      = !calm_tx;
            calm_tx_left = $urandom_range(15, 40);
        end
        calm_tx_left--;
        r = $urandom_range(0, 99);
        if (calm_tx || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one transaction and hold it until the block takes it
    task automatic offer_op(input t_op op, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] exp, input logic [TIME_W-1:0] now);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_timer_id    <= id;
        i_expire_time <= exp;
        i_now_time    <= now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.apply_timer_op(op, id, exp, now);
    endtask

    // Extremes, every status code and a full list drained by one tick
    task automatic run_directed();
        offer_op(OP_TICK,   8'd0,   $urandom(),   32'd0);
        offer_op(OP_DELETE, 8'd0,   $urandom(),   $urandom());
        offer_op(OP_ADJUST, 8'd255, 32'd9,        $urandom());
        offer_op(OP_INSERT, 8'd0,   32'd0,        $urandom());
        offer_op(OP_INSERT, 8'd255, 32'hFFFFFFFF, $urandom());
        offer_op(OP_INSERT, 8'd0,   32'd7,        $urandom());
        offer_op(OP_INSERT, 8'd5,   32'd100,      $urandom());
        offer_op(OP_INSERT, 8'd6,   32'd100,      $urandom());
        offer_op(OP_ADJUST, 8'd6,   32'd50,       $urandom());
        offer_op(OP_ADJUST, 8'd5,   32'd200,      $urandom());
        offer_op(OP_DELETE, 8'd255, $urandom(),   $urandom());
        offer_op(OP_TICK,   8'd77,  $urandom(),   32'd100);
        for (int i = 16; i < 31; i++)
            offer_op(OP_INSERT, 8'(i), 32'($urandom_range(150, 260)), $urandom());
        offer_op(OP_INSERT, 8'd40,  32'd1,        $urandom());
        offer_op(OP_TICK,   8'd3,   $urandom(),   32'hFFFFFFFF);
    endtask

    // Random operations over a small id pool and a slowly advancing clock
    task automatic run_random();
        int              r;
        t_op             op;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] exp;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] clock_base;
        clock_base = $urandom();
        for (int n = 0; n < RANDOM_OPS; n++) begin
            r   = $urandom_range(0, 99);
            id  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 23))
                                                : 8'($urandom_range(0, 255));
            exp = ($urandom_range(0, 9) == 0) ? $urandom()
                                               : clock_base + $urandom_range(0, 300);
            now = $urandom();
            if (r < 40)
                op = OP_INSERT;
            else if (r < 55)
                op = OP_DELETE;
            else if (r < 70)
                op = OP_ADJUST;
            else begin
                op = OP_TICK;
                if ($urandom_range(0, 11) != 0)
                    now = clock_base + $urandom_range(0, 150);
                clock_base = now;
            end
            offer_op(op, id, exp, now);
        end
    endtask

    // Stimulus, drain and verdict
    initial begin
        board         = new();
        calm_tx       = 1'b0;
        calm_tx_left  = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_op          <= OP_INSERT;
        i_timer_id    <= '0;
        i_expire_time <= '0;
        i_now_time    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side: check each transaction, stall at random, hold off once at length
    initial begin
        int  r;
        int  stall_left;
        int  mode_left;
        bit  calm_rx;
        bit  pressure_done;
        stall_left    = 0;
        mode_left     = 0;
        calm_rx       = 1'b0;
        pressure_done = 1'b0;
        results_seen  = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                board.check_timer_result(o_status, o_expired_id, o_expired_at, o_last);
                results_seen++;
            end
            if (mode_left == 0) begin
                calm_rx   = !calm_rx;
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            r = $urandom_range(0, 99);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!pressure_done && results_seen >= 60) begin
                pressure_done = 1'b1;
                stall_left    = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else if (!calm_rx && r < 20) begin
                stall_left = $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else if (!calm_rx && r < 22) begin
                stall_left = $urandom_range(10, 40);
                i_stall <= 1'b1;
            end else
                i_stall <= 1'b0;
        end
    end

    // Watchdog
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
